>>> rtl/assert_macros.svh
// Assertion macros for the checker file.
// Each macro expects clk and rst to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LPHT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lpht: assertion failed");

// Next-cycle implication, disabled during reset.
`define LPHT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lpht: assertion failed");

`endif

>>> rtl/lpht_pkg.sv
// Shared types and constants for the linear probing hash table.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package lpht_pkg;

  // Table size must be a power of two: the home slot is the low key bits.
  localparam int TABLE_SIZE = 8;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int OP_W       = 2;
  localparam int KEY_W      = 31;
  localparam int DATA_W     = 64;
  localparam int STAT_W     = 3;
  localparam int POS_W      = 3;

  typedef enum logic [1:0] {
    SLOT_EMPTY    = 2'd0,
    SLOT_DELETED  = 2'd1,
    SLOT_OCCUPIED = 2'd2
  } slot_state_t;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_INSERTED  = 3'd0,
    STAT_DUPLICATE = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_FOUND     = 3'd3,
    STAT_NOT_FOUND = 3'd4,
    STAT_DELETED   = 3'd5
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_PROBE
  } fsm_state_t;

  typedef struct packed {
    slot_state_t         state;
    logic [KEY_W-1:0]    key;
    logic [DATA_W-1:0]   data;
  } slot_entry_t;

  typedef struct packed {
    logic                en;
    logic [IDX_W-1:0]    addr;
    slot_entry_t         entry;
  } ram_wr_t;

endpackage

>>> rtl/linear_probe_hash_table.sv
// Operation: a request probes one slot per cycle from its home slot, up to TABLE_SIZE slots;
// the result strobe (done) is registered from the probe cycle that finishes the request.
// Flow: busy drops with the strobe and a request is taken only while idle, so the block
// finishes one request before it takes the next; the single read port of the slot RAM sets the probe rate.
// Reset: synchronous; all slots read as empty at once, no clearing pass; results never stall.
`timescale 1ns / 1ps

module linear_probe_hash_table (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [lpht_pkg::OP_W-1:0]       req_type,
  input  logic [lpht_pkg::KEY_W-1:0]      key,
  input  logic [lpht_pkg::DATA_W-1:0]     record_data,
  output logic                            done,
  output logic [lpht_pkg::STAT_W-1:0]     status,
  output logic [lpht_pkg::POS_W-1:0]      position,
  output logic [lpht_pkg::DATA_W-1:0]     found_data
);
  import lpht_pkg::*;

  fsm_state_t          state, state_next;
  op_t                 op;
  logic [KEY_W-1:0]    key_q;
  logic [DATA_W-1:0]   data_q;
  logic [IDX_W-1:0]    addr;
  logic [IDX_W-1:0]    count;

  logic [IDX_W-1:0]    rd_addr;
  slot_entry_t         rd_entry;
  ram_wr_t             wr;

  logic                finish;
  status_t             res_status;
  logic [IDX_W-1:0]    res_pos;
  logic [DATA_W-1:0]   res_data;
  logic                last;
  logic                key_hit;

  lpht_slot_ram u_ram (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (rd_addr),
    .wr       (wr),
    .rd_entry (rd_entry)
  );

  // Idle: read the home slot so it is ready in the first probe cycle.
  assign rd_addr = (state == S_IDLE) ? key[IDX_W-1:0] : addr + 1'b1;
  assign busy    = (state != S_IDLE);
  assign last    = (count == IDX_W'(TABLE_SIZE - 1));
  assign key_hit = (rd_entry.key == key_q);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (start)  state_next = S_PROBE;
      S_PROBE: if (finish) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    finish     = 1'b0;
    res_status = STAT_NOT_FOUND;
    res_pos    = addr;
    res_data   = '0;
    wr         = '0;
    wr.addr    = addr;
    if (state == S_PROBE) begin
      unique case (op)
        OP_INSERT: begin
          if (rd_entry.state != SLOT_OCCUPIED) begin
            finish     = 1'b1;
            res_status = STAT_INSERTED;
            wr.en      = 1'b1;
            wr.entry   = '{state: SLOT_OCCUPIED, key: key_q, data: data_q};
          end else if (key_hit) begin
            finish     = 1'b1;
            res_status = STAT_DUPLICATE;
          end else if (last) begin
            finish     = 1'b1;
            res_status = STAT_FULL;
            res_pos    = '0;
          end
        end
        OP_DELETE, OP_SEARCH: begin
          if (rd_entry.state == SLOT_EMPTY) begin
            finish  = 1'b1;
            res_pos = '0;
          end else if (rd_entry.state == SLOT_OCCUPIED && key_hit) begin
            finish = 1'b1;
            if (op == OP_DELETE) begin
              res_status = STAT_DELETED;
              wr.en      = 1'b1;
              wr.entry   = '{state: SLOT_DELETED, key: rd_entry.key, data: rd_entry.data};
            end else begin
              res_status = STAT_FOUND;
              res_data   = rd_entry.data;
            end
          end else if (last) begin
            finish  = 1'b1;
            res_pos = '0;
          end
        end
        default: begin
          // Unused operation code: answer not found, leave the table alone.
          finish  = 1'b1;
          res_pos = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= finish;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      op     <= op_t'(req_type);
      key_q  <= key;
      data_q <= record_data;
      addr   <= key[IDX_W-1:0];
      count  <= '0;
    end else if (state == S_PROBE && !finish) begin
      // Advance to the next slot, wrapping at the table end.
      addr  <= addr + 1'b1;
      count <= count + 1'b1;
    end
    if (finish) begin
      status     <= res_status;
      position   <= POS_W'(res_pos);
      found_data <= res_data;
    end
  end

endmodule

>>> rtl/lpht_slot_ram.sv
// Slot memory: one synchronous RAM of slot entries with a registered read.
// Per-slot valid flops make unwritten slots read as empty. Uses lpht_pkg.
`timescale 1ns / 1ps

module lpht_slot_ram (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [lpht_pkg::IDX_W-1:0]      rd_addr,
  input  lpht_pkg::ram_wr_t               wr,
  output lpht_pkg::slot_entry_t           rd_entry
);
  import lpht_pkg::*;

  slot_entry_t             mem [TABLE_SIZE];
  logic [TABLE_SIZE-1:0]   valid;
  slot_entry_t             rd_q;
  logic                    rd_valid;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.entry;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr.en) begin
        valid[wr.addr] <= 1'b1;
      end
      rd_valid <= valid[rd_addr];
    end
  end

  // A never-written slot reads as empty.
  always_comb begin
    rd_entry = rd_q;
    if (!rd_valid) begin
      rd_entry.state = SLOT_EMPTY;
    end
  end

endmodule

>>> rtl/lpht_checker.sv
// Port-level checker for linear_probe_hash_table, attached by bind.
// Depends on lpht_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lpht_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            busy,
  input  logic                            done,
  input  logic [lpht_pkg::STAT_W-1:0]     status,
  input  logic [lpht_pkg::POS_W-1:0]      position,
  input  logic [lpht_pkg::DATA_W-1:0]     found_data
);
  import lpht_pkg::*;

  `LPHT_ASSERT_NXT(a_accept_busy, start && !busy, busy)
  `LPHT_ASSERT_IMP(a_done_idle, done, !busy)
  `LPHT_ASSERT_IMP(a_done_after_busy, done, $past(busy))
  `LPHT_ASSERT_IMP(a_miss_zero, done && (status == STAT_FULL || status == STAT_NOT_FOUND), position == '0 && found_data == '0)
  `LPHT_ASSERT_IMP(a_data_only_found, done && status != STAT_FOUND, found_data == '0)

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .status     (status),
  .position   (position),
  .found_data (found_data)
);

>>> sim/testbench.sv
// Self-checking testbench for linear_probe_hash_table: drives insert, delete, search and unused-code
// requests, predicts every reply from its own copy of the slot table and checks each one.
// Depends on lpht_pkg (rtl/lpht_pkg.sv) and the linear_probe_hash_table RTL.
`timescale 1ns / 1ps

module testbench;
  import lpht_pkg::*;

  localparam logic [OP_W-1:0] OP_RSVD = 2'd3;   // unused code, answers not found
  localparam int POOL_N     = 10;
  localparam int CHAIN_HOME = 3;
  localparam logic [KEY_W-1:0]  KEY_MAX  = {KEY_W{1'b1}};
  localparam logic [DATA_W-1:0] DATA_MAX = {DATA_W{1'b1}};

  typedef struct packed {
    status_t              st;
    logic [POS_W-1:0]     pos;
    logic [DATA_W-1:0]    data;
  } hash_reply_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [OP_W-1:0]      req_type;
  logic [KEY_W-1:0]     key;
  logic [DATA_W-1:0]    record_data;
  logic                 done;
  logic [STAT_W-1:0]    status;
  logic [POS_W-1:0]     position;
  logic [DATA_W-1:0]    found_data;

  // Shadow of the slot table
  slot_state_t          tbl_state [TABLE_SIZE];
  logic [KEY_W-1:0]     tbl_key   [TABLE_SIZE];
  logic [DATA_W-1:0]    tbl_data  [TABLE_SIZE];

  hash_reply_t          hash_reply_q [$];
  hash_reply_t          want;
  logic [KEY_W-1:0]     key_pool [POOL_N];
  int                   status_seen [0:(1 << STAT_W) - 1];
  int                   error_count = 0;
  int                   request_count = 0;
  int                   burst_left = 0;

  always #5 clk = ~clk;

  linear_probe_hash_table u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req_type    (req_type),
    .key         (key),
    .record_data (record_data),
    .done        (done),
    .status      (status),
    .position    (position),
    .found_data  (found_data)
  );

  // Apply one request to the shadow table and return the reply it should produce.
  function automatic hash_reply_t probe_table(input logic [OP_W-1:0] op,
                                              input logic [KEY_W-1:0] k,
                                              input logic [DATA_W-1:0] d);
    hash_reply_t r;
    int home;
    int n;
    int p;
    int hit;
    r.st   = STAT_NOT_FOUND;
    r.pos  = '0;
    r.data = '0;
    home   = int'(k % TABLE_SIZE);
    hit    = -1;
    if (op == OP_INSERT) begin
      r.st = STAT_FULL;
      for (n = 0; n < TABLE_SIZE; n++) begin
        p = (home + n) % TABLE_SIZE;
        // a tombstone is reused before any later duplicate is seen
        if (tbl_state[p] != SLOT_OCCUPIED) begin
          tbl_state[p] = SLOT_OCCUPIED;
          tbl_key[p]   = k;
          tbl_data[p]  = d;
          r.st  = STAT_INSERTED;
          r.pos = p[POS_W-1:0];
          break;
        end
        if (tbl_key[p] == k) begin
          r.st  = STAT_DUPLICATE;
          r.pos = p[POS_W-1:0];
          break;
        end
      end
    end else if (op == OP_DELETE || op == OP_SEARCH) begin
      for (n = 0; n < TABLE_SIZE; n++) begin
        p = (home + n) % TABLE_SIZE;
        if (tbl_state[p] == SLOT_EMPTY) break;
        if (tbl_state[p] == SLOT_OCCUPIED && tbl_key[p] == k) begin
          hit = p;
          break;
        end
      end
      if (hit >= 0 && op == OP_DELETE) begin
        tbl_state[hit] = SLOT_DELETED;
        r.st  = STAT_DELETED;
        r.pos = hit[POS_W-1:0];
      end else if (hit >= 0) begin
        r.st   = STAT_FOUND;
        r.pos  = hit[POS_W-1:0];
        r.data = tbl_data[hit];
      end
    end
    return r;
  endfunction

  // Present one request and hold it until the block takes it; start stays high on return.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k,
                              input logic [DATA_W-1:0] d);
    start       <= 1'b1;
    req_type    <= op;
    key         <= k;
    record_data <= d;
    do @(posedge clk); while (busy);
    hash_reply_q.push_back(probe_table(op, k, d));
    request_count++;
  endtask

  // Bursts of back-to-back requests, mostly separated by random idle gaps
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic issue(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k,
                       input logic [DATA_W-1:0] d);
    send_request(op, k, d);
    pace_sender();
  endtask

  // Empty-table miss, key and payload extremes, duplicate, unused code, delete hits, search miss after delete
  task automatic test_extremes();
    issue(OP_SEARCH, '0, DATA_MAX);
    issue(OP_INSERT, '0, '0);
    issue(OP_INSERT, KEY_MAX, DATA_MAX);
    issue(OP_SEARCH, '0, '0);
    issue(OP_SEARCH, KEY_MAX, '0);
    issue(OP_INSERT, '0, DATA_MAX);
    issue(OP_RSVD, KEY_MAX, DATA_MAX);
    issue(OP_DELETE, KEY_MAX, '0);
    issue(OP_SEARCH, KEY_MAX, '0);
    issue(OP_DELETE, '0, '0);
  endtask

  // One probe chain wrapping past the last slot until the table is full
  task automatic test_wraparound_full();
    int i;
    for (i = 0; i < TABLE_SIZE; i++)
      issue(OP_INSERT, KEY_W'(CHAIN_HOME + TABLE_SIZE * i), {$urandom, $urandom});
    issue(OP_INSERT, KEY_W'(CHAIN_HOME + TABLE_SIZE * TABLE_SIZE), {$urandom, $urandom});
    issue(OP_INSERT, KEY_W'(CHAIN_HOME), {$urandom, $urandom});
    issue(OP_SEARCH, KEY_W'(CHAIN_HOME + TABLE_SIZE * (TABLE_SIZE - 1)), '0);
    issue(OP_SEARCH, KEY_W'(CHAIN_HOME + TABLE_SIZE * 12), '0);
  endtask

  // Search past a tombstone, then insert reuses it ahead of the live copy of the key
  task automatic test_tombstones();
    issue(OP_DELETE, KEY_W'(CHAIN_HOME + TABLE_SIZE), '0);
    issue(OP_SEARCH, KEY_W'(CHAIN_HOME + 2 * TABLE_SIZE), '0);
    issue(OP_INSERT, KEY_W'(CHAIN_HOME + 2 * TABLE_SIZE), {$urandom, $urandom});
    issue(OP_SEARCH, KEY_W'(CHAIN_HOME + 2 * TABLE_SIZE), '0);
    issue(OP_DELETE, KEY_W'(CHAIN_HOME + 2 * TABLE_SIZE), '0);
    issue(OP_SEARCH, KEY_W'(CHAIN_HOME + 2 * TABLE_SIZE), '0);
  endtask

  // Rounds alternate between filling and draining; keys come mostly from a small
  // pool, about half of it sharing one home slot, so chains, hits and full tables recur.
  task automatic test_random_mix(input int rounds, input int per_round);
    int r;
    int i;
    int roll;
    int sel;
    int cluster;
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] k;
    for (r = 0; r < rounds; r++) begin
      cluster = $urandom_range(0, TABLE_SIZE - 1);
      for (i = 0; i < POOL_N; i++) begin
        k = KEY_W'($urandom);
        if ($urandom_range(0, 1) == 1) k[IDX_W-1:0] = cluster[IDX_W-1:0];
        key_pool[i] = k;
      end
      for (i = 0; i < per_round; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < ((r % 2 == 0) ? 55 : 20))      op = OP_INSERT;
        else if (roll < ((r % 2 == 0) ? 70 : 65)) op = OP_DELETE;
        else if (roll < 95)                       op = OP_SEARCH;
        else                                      op = OP_RSVD;
        sel = $urandom_range(0, 19);
        if (sel < 17)       k = key_pool[$urandom_range(0, POOL_N - 1)];
        else if (sel == 17) k = KEY_W'($urandom);
        else if (sel == 18) k = KEY_MAX;
        else                k = '0;
        issue(op, k, {$urandom, $urandom});
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (hash_reply_q.size() == 0) begin
        $display("%0t ERROR unexpected reply: status %0d position %0d data %h",
                 $time, status, position, found_data);
        error_count++;
      end else begin
        want = hash_reply_q.pop_front();
        status_seen[want.st]++;
        if ({status, position, found_data} !== want) begin
          $display("%0t ERROR expected status %0d position %0d data %h", $time,
                   want.st, want.pos, want.data);
          $display("%0t ERROR actual   status %0d position %0d data %h", $time,
                   status, position, found_data);
          error_count++;
        end
      end
    end
  end

  initial begin
    rst         = 1'b1;
    start       = 1'b0;
    req_type    = OP_SEARCH;
    key         = '0;
    record_data = '0;
    foreach (tbl_state[i]) tbl_state[i] = SLOT_EMPTY;
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_extremes();
    test_wraparound_full();
    test_tombstones();
    test_random_mix(7, 200);
    start <= 1'b0;

    while (hash_reply_q.size() != 0) @(posedge clk);
    repeat (2 * TABLE_SIZE) @(posedge clk);

    $display("%0d requests: %0d inserted, %0d duplicate, %0d table full", request_count,
             status_seen[STAT_INSERTED], status_seen[STAT_DUPLICATE], status_seen[STAT_FULL]);
    $display("%0d found, %0d missed, %0d deleted, %0d mismatches", status_seen[STAT_FOUND],
             status_seen[STAT_NOT_FOUND], status_seen[STAT_DELETED], error_count);
    if (error_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // Generous bound on the whole run
  initial begin
    #(2_000_000);
    $display("%0t ERROR timeout with %0d replies outstanding", $time, hash_reply_q.size());
    $display("testbench failed");
    $finish;
  end

endmodule
